// ----- rtl/spam_pkg.sv -----
package spam_pkg;

    localparam int COEF_W = 32;
    localparam int EXPO_W = 16;
    localparam int SUM_W  = COEF_W + 1;
    localparam int FUNC_W = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd2;

    typedef struct packed {
        logic [EXPO_W-1:0]        expo;
        logic signed [COEF_W-1:0] coef;
    } term_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic ovf_emit;
        logic empty_emit;
        logic merge_start;
        logic merge_step;
    } cmd_t;

    typedef struct packed {
        logic full_a;
        logic full_b;
        logic both_empty;
        logic last_step;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/spam_ctrl.sv -----
module spam_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [spam_pkg::FUNC_W-1:0]  in_func,
    output logic                         in_ready,
    input  spam_pkg::sts_t               sts,
    output spam_pkg::cmd_t               cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    logic state_reg;
    logic state_next;
    logic acc;
    logic is_a;
    logic is_b;
    logic is_start;

    assign in_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign acc      = in_valid && in_ready;
    assign is_a     = (in_func == spam_pkg::FUNC_LOAD_A);
    assign is_b     = (in_func == spam_pkg::FUNC_LOAD_B);
    assign is_start = (in_func == spam_pkg::FUNC_START);

    always_comb
    begin
        cmd.load_a      = acc && is_a && !sts.full_a;
        cmd.load_b      = acc && is_b && !sts.full_b;
        cmd.ovf_emit    = acc && ((is_a && sts.full_a) || (is_b && sts.full_b));
        cmd.empty_emit  = acc && is_start && sts.both_empty;
        cmd.merge_start = acc && is_start && !sts.both_empty;
        cmd.merge_step  = (state_reg == ST_MERGE) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.merge_start)
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (cmd.merge_step && sts.last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/spam_dp.sv -----
module spam_dp
#(
    parameter int MAX_TERMS = 32
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  spam_pkg::cmd_t                   cmd,
    output spam_pkg::sts_t                   sts,
    input  logic [spam_pkg::COEF_W-1:0]      in_coef,
    input  logic [spam_pkg::EXPO_W-1:0]      in_expo,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [spam_pkg::SUM_W-1:0] out_coef,
    output logic [spam_pkg::EXPO_W-1:0]      out_expo,
    output logic                             out_term_valid,
    output logic                             out_last,
    output logic                             out_overflow
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    spam_pkg::term_t mem_a [MAX_TERMS];
    spam_pkg::term_t mem_b [MAX_TERMS];
    spam_pkg::term_t rd_a_reg;
    spam_pkg::term_t rd_b_reg;
    spam_pkg::term_t wr_term;

    logic [CNT_W-1:0] count_a_reg;
    logic [CNT_W-1:0] count_a_next;
    logic [CNT_W-1:0] count_b_reg;
    logic [CNT_W-1:0] count_b_next;
    logic [CNT_W-1:0] ia_reg;
    logic [CNT_W-1:0] ia_next;
    logic [CNT_W-1:0] ib_reg;
    logic [CNT_W-1:0] ib_next;
    logic [CNT_W-1:0] ia_adv;
    logic [CNT_W-1:0] ib_adv;

    logic a_has;
    logic b_has;
    logic take_a;
    logic take_b;
    logic signed [spam_pkg::SUM_W-1:0] sum;
    logic [spam_pkg::EXPO_W-1:0]       sum_expo;

    logic                               out_valid_reg;
    logic signed [spam_pkg::SUM_W-1:0]  out_coef_reg;
    logic [spam_pkg::EXPO_W-1:0]        out_expo_reg;
    logic                               out_term_valid_reg;
    logic                               out_last_reg;
    logic                               out_overflow_reg;

    assign wr_term.coef = in_coef;
    assign wr_term.expo = in_expo;

    assign a_has = (ia_reg < count_a_reg);
    assign b_has = (ib_reg < count_b_reg);

    always_comb
    begin
        take_a = 1'b0;
        take_b = 1'b0;
        if (a_has && b_has)
        begin
            take_a = (rd_a_reg.expo >= rd_b_reg.expo);
            take_b = (rd_a_reg.expo <= rd_b_reg.expo);
        end
        else if (a_has)
        begin
            take_a = 1'b1;
        end
        else
        begin
            take_b = 1'b1;
        end
    end

    always_comb
    begin
        sum = (take_a ? spam_pkg::SUM_W'(rd_a_reg.coef) : '0)
            + (take_b ? spam_pkg::SUM_W'(rd_b_reg.coef) : '0);
        sum_expo = take_a ? rd_a_reg.expo : rd_b_reg.expo;
    end

    assign ia_adv = ia_reg + CNT_W'(take_a);
    assign ib_adv = ib_reg + CNT_W'(take_b);

    always_comb
    begin
        sts.full_a     = (count_a_reg == CNT_W'(MAX_TERMS));
        sts.full_b     = (count_b_reg == CNT_W'(MAX_TERMS));
        sts.both_empty = (count_a_reg == '0) && (count_b_reg == '0);
        sts.last_step  = (ia_adv == count_a_reg) && (ib_adv == count_b_reg);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        ia_next      = ia_reg;
        ib_next      = ib_reg;
        if (cmd.load_a)
        begin
            count_a_next = count_a_reg + CNT_W'(1);
        end
        if (cmd.load_b)
        begin
            count_b_next = count_b_reg + CNT_W'(1);
        end
        if (cmd.merge_start)
        begin
            ia_next = '0;
            ib_next = '0;
        end
        else if (cmd.merge_step)
        begin
            if (sts.last_step)
            begin
                ia_next      = '0;
                ib_next      = '0;
                count_a_next = '0;
                count_b_next = '0;
            end
            else
            begin
                ia_next = ia_adv;
                ib_next = ib_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg <= '0;
            count_b_reg <= '0;
            ia_reg      <= '0;
            ib_reg      <= '0;
        end
        else
        begin
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            ia_reg      <= ia_next;
            ib_reg      <= ib_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
        begin
            mem_a[count_a_reg[IDX_W-1:0]] <= wr_term;
        end
        rd_a_reg <= mem_a[ia_next[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_b)
        begin
            mem_b[count_b_reg[IDX_W-1:0]] <= wr_term;
        end
        rd_b_reg <= mem_b[ib_next[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ovf_emit || cmd.empty_emit || cmd.merge_step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ovf_emit || cmd.empty_emit)
        begin
            out_coef_reg       <= '0;
            out_expo_reg       <= '0;
            out_term_valid_reg <= 1'b0;
            out_last_reg       <= cmd.empty_emit;
            out_overflow_reg   <= cmd.ovf_emit;
        end
        else if (cmd.merge_step)
        begin
            out_coef_reg       <= sum;
            out_expo_reg       <= sum_expo;
            out_term_valid_reg <= 1'b1;
            out_last_reg       <= sts.last_step;
            out_overflow_reg   <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_coef       = out_coef_reg;
    assign out_expo       = out_expo_reg;
    assign out_term_valid = out_term_valid_reg;
    assign out_last       = out_last_reg;
    assign out_overflow   = out_overflow_reg;

endmodule

// ----- rtl/sparse_polynomial_add_merge.sv -----
// Channel   Direction  tdata                                  tuser
// s_axis    in         [31:0] coefficient, [47:32] exponent   [1:0] func
// m_axis    out        [32:0] term_coefficient,               [0] term_valid,
//                      [48:33] term_exponent                  [1] overflow
//
// A load beat into a full store is answered with one overflow beat.
// A start beat emits one result beat per cycle unless m_axis stalls, one per merged term, or
// one empty tlast beat if both stores are empty; each merge step reads one entry of each store.
// Inputs are held off from start acceptance until the tlast beat is issued.
// rst_n clears the term counts and the controller; store contents stay.
// A stalled m_axis holds the current beat and freezes the merge.
module sparse_polynomial_add_merge
#(
    parameter int MAX_TERMS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [spam_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // coefficient, exponent
    input  logic [spam_pkg::FUNC_W-1:0]          s_axis_tuser,  // func
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [spam_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // term_coefficient, term_exponent
    output logic [spam_pkg::OUT_USER_W-1:0]      m_axis_tuser,  // term_valid, overflow
    output logic                                 m_axis_tlast
);

    spam_pkg::cmd_t cmd;
    spam_pkg::sts_t sts;

    logic signed [spam_pkg::SUM_W-1:0] out_coef;
    logic [spam_pkg::EXPO_W-1:0]       out_expo;
    logic                              out_term_valid;
    logic                              out_overflow;

    spam_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spam_dp #(.MAX_TERMS(MAX_TERMS)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_coef        (s_axis_tdata[spam_pkg::COEF_W-1:0]),
        .in_expo        (s_axis_tdata[spam_pkg::COEF_W +: spam_pkg::EXPO_W]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_coef       (out_coef),
        .out_expo       (out_expo),
        .out_term_valid (out_term_valid),
        .out_last       (m_axis_tlast),
        .out_overflow   (out_overflow)
    );

    assign m_axis_tdata = {
        (spam_pkg::OUT_DATA_W - spam_pkg::SUM_W - spam_pkg::EXPO_W)'(0),
        out_expo,
        out_coef
    };
    assign m_axis_tuser = {out_overflow, out_term_valid};

    a_ovf_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (!m_axis_tlast && !m_axis_tuser[0]))
        else $error("overflow beat carries a term or tlast");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("empty sum beat without tlast");

    a_start_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == spam_pkg::FUNC_START))
        |=> ##[0:1] (m_axis_tvalid && !m_axis_tuser[1]))
        else $error("start beat produced no result beat");

endmodule

// ----- tb/sv/tb_sparse_polynomial_add_merge.sv -----
`timescale 1ns / 100ps

module tb_sparse_polynomial_add_merge;

    localparam int MAX_TERMS = 32;
    localparam logic [spam_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [spam_pkg::FUNC_W-1:0] func;
        logic [spam_pkg::COEF_W-1:0] coef;
        logic [spam_pkg::EXPO_W-1:0] expo;
    } beat_t;

    typedef struct {
        logic [spam_pkg::SUM_W-1:0]  coef;
        logic [spam_pkg::EXPO_W-1:0] expo;
        logic                        valid;
        logic                        last;
        logic                        ovf;
    } sum_term_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [spam_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [spam_pkg::FUNC_W-1:0]     s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [spam_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [spam_pkg::OUT_USER_W-1:0] m_axis_tuser;
    logic                            m_axis_tlast;

    beat_t           pending_beats[$];
    sum_term_t       sum_terms_due[$];
    spam_pkg::term_t poly_a[MAX_TERMS];
    spam_pkg::term_t poly_b[MAX_TERMS];
    int              terms_in_a = 0;
    int              terms_in_b = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              failures = 0;

    sparse_polynomial_add_merge #(.MAX_TERMS(MAX_TERMS)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [spam_pkg::SUM_W-1:0] widen(logic [spam_pkg::COEF_W-1:0] c);
        return {c[spam_pkg::COEF_W-1], c};
    endfunction

    function automatic void push_term(logic [spam_pkg::SUM_W-1:0] c,
                                      logic [spam_pkg::EXPO_W-1:0] e,
                                      logic v, logic l, logic o);
        sum_term_t t;
        t.coef  = c;
        t.expo  = e;
        t.valid = v;
        t.last  = l;
        t.ovf   = o;
        sum_terms_due.push_back(t);
    endfunction

    function automatic void merge_polys();
        int ia;
        int ib;
        logic [spam_pkg::SUM_W-1:0]  c;
        logic [spam_pkg::EXPO_W-1:0] e;
        ia = 0;
        ib = 0;
        if (terms_in_a == 0 && terms_in_b == 0)
        begin
            push_term('0, '0, 1'b0, 1'b1, 1'b0);
            return;
        end
        while (ia < terms_in_a || ib < terms_in_b)
        begin
            if (ia < terms_in_a && ib < terms_in_b && poly_a[ia].expo == poly_b[ib].expo)
            begin
                c = widen(poly_a[ia].coef) + widen(poly_b[ib].coef);
                e = poly_a[ia].expo;
                ia++;
                ib++;
            end
            else if (ib >= terms_in_b || (ia < terms_in_a && poly_a[ia].expo > poly_b[ib].expo))
            begin
                c = widen(poly_a[ia].coef);
                e = poly_a[ia].expo;
                ia++;
            end
            else
            begin
                c = widen(poly_b[ib].coef);
                e = poly_b[ib].expo;
                ib++;
            end
            push_term(c, e, 1'b1, ia >= terms_in_a && ib >= terms_in_b, 1'b0);
        end
        terms_in_a = 0;
        terms_in_b = 0;
    endfunction

    function automatic void absorb_beat(beat_t b);
        case (b.func)
            spam_pkg::FUNC_LOAD_A:
                if (terms_in_a >= MAX_TERMS)
                    push_term('0, '0, 1'b0, 1'b0, 1'b1);
                else
                begin
                    poly_a[terms_in_a].coef = b.coef;
                    poly_a[terms_in_a].expo = b.expo;
                    terms_in_a++;
                end
            spam_pkg::FUNC_LOAD_B:
                if (terms_in_b >= MAX_TERMS)
                    push_term('0, '0, 1'b0, 1'b0, 1'b1);
                else
                begin
                    poly_b[terms_in_b].coef = b.coef;
                    poly_b[terms_in_b].expo = b.expo;
                    terms_in_b++;
                end
            spam_pkg::FUNC_START:
                merge_polys();
            default:
                ;
        endcase
    endfunction

    always @(posedge clk)
    begin : drive_blk
        logic  fire;
        beat_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire)
                absorb_beat(pending_beats.pop_front());
            // hold an offered beat until taken
            if (!s_axis_tvalid || fire)
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_beats[0];
                    s_axis_tdata  <= {nxt.expo, nxt.coef};
                    s_axis_tuser  <= nxt.func;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [spam_pkg::SUM_W-1:0] want,
                                        logic [spam_pkg::SUM_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : watch_blk
        sum_term_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (sum_terms_due.size() == 0)
                begin
                    $error("unexpected result beat: tdata 0x%0h tuser 0x%0h tlast %0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    failures++;
                end
                else
                begin
                    want = sum_terms_due.pop_front();
                    check_field("term_coefficient", want.coef,
                                m_axis_tdata[spam_pkg::SUM_W-1:0]);
                    check_field("term_exponent", spam_pkg::SUM_W'(want.expo),
                                spam_pkg::SUM_W'(m_axis_tdata[spam_pkg::SUM_W +:
                                                              spam_pkg::EXPO_W]));
                    check_field("term_valid", spam_pkg::SUM_W'(want.valid),
                                spam_pkg::SUM_W'(m_axis_tuser[0]));
                    check_field("overflow", spam_pkg::SUM_W'(want.ovf),
                                spam_pkg::SUM_W'(m_axis_tuser[1]));
                    check_field("last", spam_pkg::SUM_W'(want.last),
                                spam_pkg::SUM_W'(m_axis_tlast));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void queue_beat(logic [spam_pkg::FUNC_W-1:0] f,
                                       logic [spam_pkg::COEF_W-1:0] c,
                                       logic [spam_pkg::EXPO_W-1:0] e);
        beat_t b;
        b.func = f;
        b.coef = c;
        b.expo = e;
        pending_beats.push_back(b);
    endfunction

    function automatic logic [spam_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            4, 5: return spam_pkg::COEF_W'($signed($urandom_range(6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    // Load two term lists in random interleave, then start; returns beats counted.
    function automatic int queue_merge(int na, int nb, bit ordered);
        int    step;
        int    hi;
        int    ea;
        int    eb;
        beat_t qa[$];
        beat_t qb[$];
        beat_t b;
        case ($urandom_range(4))
            0: step = 1;
            1: step = 2;
            2: step = 3;
            3: step = 50;
            default: step = 2000;
        endcase
        if ((na > nb ? na : nb) * step > 65535)
            step = 1;
        hi = $urandom_range(65535, (na > nb ? na : nb) * step);
        ea = hi;
        eb = hi;
        for (int i = 0; i < na; i++)
        begin
            ea = ea - $urandom_range(i == 0 ? 0 : 1, step);
            b.func = spam_pkg::FUNC_LOAD_A;
            b.coef = pick_coef();
            b.expo = ordered ? spam_pkg::EXPO_W'(ea) : spam_pkg::EXPO_W'($urandom_range(15));
            qa.push_back(b);
        end
        for (int i = 0; i < nb; i++)
        begin
            eb = eb - $urandom_range(i == 0 ? 0 : 1, step);
            b.func = spam_pkg::FUNC_LOAD_B;
            b.coef = pick_coef();
            b.expo = ordered ? spam_pkg::EXPO_W'(eb) : spam_pkg::EXPO_W'($urandom_range(15));
            qb.push_back(b);
        end
        while (qa.size() > 0 || qb.size() > 0)
        begin
            if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(1)))
                pending_beats.push_back(qa.pop_front());
            else
                pending_beats.push_back(qb.pop_front());
        end
        queue_beat(spam_pkg::FUNC_START, $urandom, spam_pkg::EXPO_W'($urandom));
        return na + nb + 1;
    endfunction

    task automatic drain();
        while (pending_beats.size() > 0 || sum_terms_due.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin : stim_blk
        int made;
        int roll;
        int f;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        queue_beat(spam_pkg::FUNC_START, '0, '0);
        queue_beat(spam_pkg::FUNC_LOAD_A, 32'h7fff_ffff, 16'hffff);
        queue_beat(spam_pkg::FUNC_LOAD_A, 32'h8000_0000, 16'h0000);
        queue_beat(spam_pkg::FUNC_LOAD_B, 32'h7fff_ffff, 16'hffff);
        queue_beat(spam_pkg::FUNC_LOAD_B, 32'h8000_0000, 16'h0000);
        queue_beat(spam_pkg::FUNC_START, '1, '1);
        queue_beat(spam_pkg::FUNC_LOAD_A, 32'd5, 16'd10);
        queue_beat(spam_pkg::FUNC_LOAD_B, -32'sd5, 16'd10);
        queue_beat(spam_pkg::FUNC_START, '0, '0);
        queue_beat(spam_pkg::FUNC_LOAD_A, '1, 16'd300);
        queue_beat(spam_pkg::FUNC_LOAD_A, 32'd7, 16'd200);
        queue_beat(spam_pkg::FUNC_START, '0, '0);
        queue_beat(spam_pkg::FUNC_LOAD_B, 32'd1, 16'd40);
        queue_beat(spam_pkg::FUNC_LOAD_B, 32'd2, 16'd30);
        queue_beat(spam_pkg::FUNC_LOAD_B, 32'd3, 16'd20);
        queue_beat(spam_pkg::FUNC_START, '0, '0);
        queue_beat(spam_pkg::FUNC_LOAD_A, 32'd1, 16'd9);
        queue_beat(spam_pkg::FUNC_LOAD_B, 32'd3, 16'd7);
        queue_beat(spam_pkg::FUNC_LOAD_A, 32'd2, 16'd5);
        queue_beat(spam_pkg::FUNC_LOAD_B, 32'd4, 16'd5);
        queue_beat(FUNC_UNUSED, '1, '1);
        queue_beat(spam_pkg::FUNC_LOAD_B, 32'd6, 16'd1);
        queue_beat(spam_pkg::FUNC_START, '0, '0);
        queue_beat(spam_pkg::FUNC_LOAD_A, 32'd1, 16'd3);
        queue_beat(spam_pkg::FUNC_LOAD_A, 32'd2, 16'd8);
        queue_beat(spam_pkg::FUNC_LOAD_B, 32'd3, 16'd5);
        queue_beat(spam_pkg::FUNC_START, '0, '0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            made = 0;
            // fill both stores past capacity to force overflow beats
            if (ph == 1 || ph == 3)
                made += queue_merge(MAX_TERMS + $urandom_range(1, 2), MAX_TERMS + 1, 1'b1);
            while (made < 60)
            begin
                roll = $urandom_range(99);
                if (roll < 78)
                    made += queue_merge($urandom_range(6), $urandom_range(6), 1'b1);
                else if (roll < 86)
                    made += queue_merge($urandom_range(5), $urandom_range(5), 1'b0);
                else if (roll < 89)
                    made += queue_merge($urandom_range(16, MAX_TERMS),
                                        $urandom_range(16, MAX_TERMS), 1'b1);
                else
                begin
                    f = $urandom_range(3);
                    queue_beat(spam_pkg::FUNC_W'(f), pick_coef(),
                               spam_pkg::EXPO_W'($urandom));
                    if (f != FUNC_UNUSED)
                        made++;
                end
            end
            // hold off the sender until all results are back
            drain();
        end

        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
